// ===== src/rsmb_pkg.sv =====
// rsmb_pkg: shared types and constants for the rotated sorted minimum search
// holds widths, the controller state type and the command/status groups
// depends on nothing
package rsmb_pkg;

    localparam int DATA_W           = 32;
    localparam int MAX_ELEMENTS_DEF = 1024;

    // largest positive 32-bit value, start point of the running minimum
    localparam logic signed [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    // controller states
    typedef enum logic [2:0] {
        S_LOAD,
        S_RD_LM,
        S_RD_H,
        S_EVAL,
        S_EMIT
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic load;    // request accepted, store element
        logic start;   // last element taken, set up the search
        logic rd_lm;   // read low and mid entries
        logic rd_h;    // read high entry, hold low and mid data
        logic eval;    // compare and narrow the span
        logic emit;    // move running minimum to the output register
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic in_range;  // low index not past high index
        logic ordered;   // low <= mid <= high values
        logic out_free;  // output register can take a new result
    } t_status;

endpackage

// ===== src/rsmb_if.sv =====
// request and result channel interfaces for the rotated sorted minimum search
// valid/ready handshake with payload; depends on rsmb_pkg
interface rsmb_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [rsmb_pkg::DATA_W-1:0] value;
    logic                               last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface rsmb_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [rsmb_pkg::DATA_W-1:0] minimum;

    modport source (output valid, output minimum, input ready);
    modport sink   (input valid, input minimum, output ready);
endinterface

// ===== src/rsmb_ctrl.sv =====
// rsmb_ctrl: state machine sequencing load, probe reads, compare and emit
// drives commands to rsmb_dp and reads its status; depends on rsmb_pkg
module rsmb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    input  rsmb_pkg::t_status i_status,
    output logic              o_in_ready,
    output rsmb_pkg::t_cmd    o_cmd
);

    rsmb_pkg::t_state r_state;
    rsmb_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsmb_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rsmb_pkg::S_LOAD: begin
                if (i_in_valid && i_in_last) n_state = rsmb_pkg::S_RD_LM;
            end
            rsmb_pkg::S_RD_LM: begin
                n_state = i_status.in_range ? rsmb_pkg::S_RD_H : rsmb_pkg::S_EMIT;
            end
            rsmb_pkg::S_RD_H: begin
                n_state = rsmb_pkg::S_EVAL;
            end
            rsmb_pkg::S_EVAL: begin
                n_state = i_status.ordered ? rsmb_pkg::S_EMIT : rsmb_pkg::S_RD_LM;
            end
            rsmb_pkg::S_EMIT: begin
                if (i_status.out_free) n_state = rsmb_pkg::S_LOAD;
            end
            default: begin
                n_state = rsmb_pkg::S_LOAD;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            rsmb_pkg::S_LOAD: begin
                o_in_ready  = 1'b1;
                o_cmd.load  = i_in_valid;
                o_cmd.start = i_in_valid && i_in_last;
            end
            rsmb_pkg::S_RD_LM: begin
                o_cmd.rd_lm = i_status.in_range;
            end
            rsmb_pkg::S_RD_H: begin
                o_cmd.rd_h = 1'b1;
            end
            rsmb_pkg::S_EVAL: begin
                o_cmd.eval = 1'b1;
            end
            rsmb_pkg::S_EMIT: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== src/rsmb_dp.sv =====
// rsmb_dp: element store, search indices, running minimum and output register
// follows commands from rsmb_ctrl; depends on rsmb_pkg
module rsmb_dp #(
    parameter int MAX_ELEMENTS = rsmb_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  rsmb_pkg::t_cmd                     i_cmd,
    input  logic signed [rsmb_pkg::DATA_W-1:0] i_value,
    input  logic                               i_out_ready,
    output rsmb_pkg::t_status                  o_status,
    output logic                               o_out_valid,
    output logic signed [rsmb_pkg::DATA_W-1:0] o_minimum
);

    localparam int AW = $clog2(MAX_ELEMENTS);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);

    // element store, one write and two read ports
    logic signed [rsmb_pkg::DATA_W-1:0] r_mem [MAX_ELEMENTS];
    logic signed [rsmb_pkg::DATA_W-1:0] r_qa;
    logic signed [rsmb_pkg::DATA_W-1:0] r_qb;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [CW-1:0] r_low;
    logic [CW-1:0] r_high;
    logic [CW-1:0] r_mid;
    logic [CW:0]   n_sum;
    logic [CW-1:0] n_mid;
    logic          n_room;
    logic [AW-1:0] n_addr_a;

    logic signed [rsmb_pkg::DATA_W-1:0] r_lo_v;
    logic signed [rsmb_pkg::DATA_W-1:0] r_mid_v;
    logic signed [rsmb_pkg::DATA_W-1:0] r_rmin;
    logic signed [rsmb_pkg::DATA_W-1:0] n_cand;
    logic                               n_lo_le_mid;
    logic                               n_mid_le_hi;
    logic                               r_out_valid;
    logic signed [rsmb_pkg::DATA_W-1:0] r_out;

    // index arithmetic
    always_comb begin
        n_room   = (r_count < CW'(MAX_ELEMENTS));
        n_count  = n_room ? r_count + CW'(1) : r_count;
        n_sum    = {1'b0, r_low} + {1'b0, r_high};
        n_mid    = n_sum[CW:1];
        n_addr_a = i_cmd.rd_h ? r_high[AW-1:0] : r_low[AW-1:0];
    end

    // store write and registered reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && n_room) begin
            r_mem[r_count[AW-1:0]] <= i_value;
        end
        r_qa <= r_mem[n_addr_a];
        r_qb <= r_mem[n_mid[AW-1:0]];
    end

    // probe compares; r_qa holds the high entry during evaluation
    always_comb begin
        n_lo_le_mid = (r_lo_v <= r_mid_v);
        n_mid_le_hi = (r_mid_v <= r_qa);
        n_cand      = n_lo_le_mid ? r_lo_v : r_mid_v;
    end

    // probe data holding
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_lm) begin
            r_mid <= n_mid;
        end
        if (i_cmd.rd_h) begin
            r_lo_v  <= r_qa;
            r_mid_v <= r_qb;
        end
    end

    // fill count, search span and running minimum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_low   <= '0;
            r_high  <= '0;
            r_rmin  <= rsmb_pkg::INT_MAX;
        end else if (i_cmd.start) begin
            r_count <= '0;
            r_low   <= '0;
            r_high  <= n_count - CW'(1);
            r_rmin  <= rsmb_pkg::INT_MAX;
        end else if (i_cmd.load) begin
            r_count <= n_count;
        end else if (i_cmd.eval) begin
            if (n_cand < r_rmin) r_rmin <= n_cand;
            if (!(n_lo_le_mid && n_mid_le_hi)) begin
                if (n_lo_le_mid) begin
                    r_low <= r_mid + CW'(1);
                end else begin
                    r_high <= r_mid - CW'(1);
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= r_rmin;
        end
    end

    always_comb begin
        o_status.in_range = (r_low <= r_high);
        o_status.ordered  = n_lo_le_mid && n_mid_le_hi;
        o_status.out_free = !r_out_valid || i_out_ready;
        o_out_valid       = r_out_valid;
        o_minimum         = r_out;
    end

endmodule

// ===== src/rotated_sorted_min_bsearch.sv =====
// rotated_sorted_min_bsearch: minimum of a rotated sorted array by binary search
// elements are stored one per cycle while no search runs; after the last one, each
// probe has two store read steps (low and mid, then high), then a compare; at most
// clog2(N)+1 probes, then the emit step, which waits while a result is pending
// synchronous active-low reset clears control state; store contents are not cleared
// depends on rsmb_pkg, rsmb_if, rsmb_ctrl, rsmb_dp
module rotated_sorted_min_bsearch #(
    parameter int MAX_ELEMENTS = rsmb_pkg::MAX_ELEMENTS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    rsmb_in_if.sink  i_req,
    rsmb_out_if.source o_res
);

    rsmb_pkg::t_cmd    cmd;
    rsmb_pkg::t_status status;
    logic              in_ready;
    logic              out_valid;
    logic signed [rsmb_pkg::DATA_W-1:0] minimum;

    // sequencer
    rsmb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_in_last  (i_req.last),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    // store and search datapath
    rsmb_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (i_req.value),
        .i_out_ready (o_res.ready),
        .o_status    (status),
        .o_out_valid (out_valid),
        .o_minimum   (minimum)
    );

    // channel hookup
    assign i_req.ready   = in_ready;
    assign o_res.valid   = out_valid;
    assign o_res.minimum = minimum;

`ifndef ASSERT_OFF
    // a completed array blocks further requests until the search ends
    a_last_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && i_req.last) |=> !i_req.ready)
        else $error("request taken during search");

    // a result only enters a free output register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.emit |-> (!o_res.valid || o_res.ready))
        else $error("result overwrote pending output");

    // at most one datapath step per cycle
    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load, cmd.rd_lm, cmd.rd_h, cmd.eval, cmd.emit}))
        else $error("conflicting datapath commands");
`endif

endmodule

// ===== bench/rsmb_min_checker.sv =====
`timescale 1ns / 1ps
// rsmb_min_checker: watches the request and result channels, predicts the minimum
// the rotated-array search finds for each completed array and compares the results
// depends on rsmb_pkg
module rsmb_min_checker #(
    parameter int MAX_ELEMENTS = rsmb_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_req_valid,
    input  logic                               i_req_ready,
    input  logic signed [rsmb_pkg::DATA_W-1:0] i_req_value,
    input  logic                               i_req_last,
    input  logic                               i_res_valid,
    input  logic                               i_res_ready,
    input  logic signed [rsmb_pkg::DATA_W-1:0] i_res_minimum,
    output int                                 o_pending,
    output int                                 o_mismatches,
    output int                                 o_arrays,
    output int                                 o_results
);

    typedef logic signed [rsmb_pkg::DATA_W-1:0] t_word;

    // own copy of the element store and of the minima still owed by the block
    t_word element_mem [MAX_ELEMENTS];
    int    stored_count;
    t_word expected_minima [$];
    int    mismatch_count;
    int    array_count;
    int    result_count;

    // binary search over the stored array, duplicates handled exactly as the block does
    function automatic t_word search_minimum(input int count);
        int    lo;
        int    hi;
        int    mid;
        t_word best;
        t_word lo_v;
        t_word mid_v;
        t_word hi_v;
        best = rsmb_pkg::INT_MAX;
        lo   = 0;
        hi   = count - 1;
        while (lo <= hi) begin
            mid   = (lo + hi) / 2;
            lo_v  = element_mem[lo];
            mid_v = element_mem[mid];
            hi_v  = element_mem[hi];
            // ordered span: low entry settles it
            if (lo_v <= mid_v && mid_v <= hi_v) begin
                return (lo_v < best) ? lo_v : best;
            end
            if (lo_v <= mid_v) begin
                if (lo_v < best) best = lo_v;
                lo = mid + 1;
            end else begin
                if (mid_v < best) best = mid_v;
                hi = mid - 1;
            end
        end
        return best;
    endfunction

    always @(posedge i_clk) begin
        t_word want;
        if (!i_rst_n) begin
            stored_count = 0;
            expected_minima.delete();
        end else begin
            // request side: store the element, search once the array is complete
            if (i_req_valid && i_req_ready) begin
                if (stored_count < MAX_ELEMENTS) begin
                    element_mem[stored_count] = i_req_value;
                    stored_count++;
                end
                if (i_req_last) begin
                    expected_minima.push_back(search_minimum(stored_count));
                    array_count++;
                    stored_count = 0;
                end
            end
            // result side: compare with the oldest minimum still owed
            if (i_res_valid && i_res_ready) begin
                result_count++;
                if (expected_minima.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected result minimum=%0d", $realtime,
                                 i_res_minimum);
                end else begin
                    want = expected_minima.pop_front();
                    if (i_res_minimum !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: result %0d minimum expected %0d got %0d",
                                     $realtime, result_count, want, i_res_minimum);
                    end
                end
            end
        end
        o_pending    <= expected_minima.size();
        o_mismatches <= mismatch_count;
        o_arrays     <= array_count;
        o_results    <= result_count;
    end

endmodule

// ===== bench/rotated_sorted_min_bsearch_test.sv =====
`timescale 1ns / 1ps
// rotated_sorted_min_bsearch_test: drives arrays into the block and gives the verdict
// depends on rsmb_pkg, rsmb_if, rotated_sorted_min_bsearch and rsmb_min_checker
module rotated_sorted_min_bsearch_test;

    // small store so that an overfull array stays short
    localparam int CAPACITY     = 64;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 100;
    localparam int CYCLE_LIMIT  = 600000;

    typedef logic signed [rsmb_pkg::DATA_W-1:0] t_word;
    typedef enum {ARR_SPREAD, ARR_REPEATS, ARR_NOISE} t_array_kind;

    localparam t_word WORD_MIN = {1'b1, {(rsmb_pkg::DATA_W-1){1'b0}}};

    logic i_clk;
    logic i_rst_n;

    rsmb_in_if  req_if ();
    rsmb_out_if res_if ();

    int pending;
    int mismatches;
    int arrays;
    int results;
    int send_gap_max;
    int recv_gap_max;
    int items_sent;
    int cycle_count;
    bit hold_request;
    bit hold_done;

    rotated_sorted_min_bsearch #(
        .MAX_ELEMENTS (CAPACITY)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    rsmb_min_checker #(
        .MAX_ELEMENTS (CAPACITY)
    ) i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (req_if.valid),
        .i_req_ready   (req_if.ready),
        .i_req_value   (req_if.value),
        .i_req_last    (req_if.last),
        .i_res_valid   (res_if.valid),
        .i_res_ready   (res_if.ready),
        .i_res_minimum (res_if.minimum),
        .o_pending     (pending),
        .o_mismatches  (mismatches),
        .o_arrays      (arrays),
        .o_results     (results)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("no finish after %0d cycles", cycle_count);
        $display("end of test: mismatches");
        $finish;
    end

    // result side: random gap before each result, one long hold when asked for
    initial begin
        int gap;
        res_if.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            gap = $urandom_range(0, recv_gap_max);
            if (hold_request && !hold_done) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (gap > 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            res_if.ready <= 1'b1;
            @(posedge i_clk);
            while (!res_if.valid) @(posedge i_clk);
        end
    end

    // one request, after a random gap, held until accepted
    task automatic send_element(input t_word value, input logic last);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.value <= value;
        req_if.last  <= last;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_values(input t_word vals [$]);
        for (int i = 0; i < vals.size(); i++)
            send_element(vals[i], i == vals.size() - 1);
    endtask

    // sorted then rotated array; noise arrays keep the order drawn
    task automatic send_array(input t_array_kind kind, input int len);
        t_word sorted_vals [$];
        t_word vals [$];
        t_word v;
        int    j;
        int    turn;
        for (int i = 0; i < len; i++) begin
            if (kind == ARR_REPEATS)
                v = t_word'($urandom_range(0, 6)) - 3;
            else
                v = t_word'($urandom());
            if (kind == ARR_SPREAD && $urandom_range(0, 15) == 0)
                v = $urandom_range(0, 1) ? rsmb_pkg::INT_MAX : WORD_MIN;
            j = sorted_vals.size();
            if (kind != ARR_NOISE)
                while (j > 0 && sorted_vals[j-1] > v) j--;
            sorted_vals.insert(j, v);
        end
        turn = $urandom_range(0, len - 1);
        for (int i = 0; i < len; i++)
            vals.push_back(sorted_vals[(i + turn) % len]);
        send_values(vals);
    endtask

    // arrays of mixed kind, mostly short, until the request budget is used
    task automatic run_arrays(input int budget);
        int          stop_at;
        int          pick;
        int          len;
        t_array_kind kind;
        stop_at = items_sent + budget;
        while (items_sent < stop_at) begin
            pick = $urandom_range(0, 9);
            kind = (pick < 6) ? ARR_SPREAD : (pick < 8) ? ARR_REPEATS : ARR_NOISE;
            len  = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64)
                                               : $urandom_range(1, 16);
            send_array(kind, len);
        end
    endtask

    // stimulus
    initial begin
        t_word vals [$];
        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.value <= '0;
        req_if.last  <= 1'b0;
        send_gap_max = 10;
        recv_gap_max = 10;
        items_sent   = 0;
        hold_request = 1'b0;
        hold_done    = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: single elements at both extremes, extremes in both orders
        vals = '{WORD_MIN};
        send_values(vals);
        vals = '{rsmb_pkg::INT_MAX};
        send_values(vals);
        vals = '{rsmb_pkg::INT_MAX, WORD_MIN};
        send_values(vals);
        vals = '{WORD_MIN, rsmb_pkg::INT_MAX};
        send_values(vals);
        // plain rotation
        vals = '{3, 4, 5, 1, 2};
        send_values(vals);
        // repeats hide the true minimum from the search
        vals = '{1, 1, 1, 0, 1};
        send_values(vals);
        // all equal
        vals = '{-1, -1, -1};
        send_values(vals);
        // not a rotated sorted array at all
        vals = '{5, 4, 3, 2, 1};
        send_values(vals);

        // sender pauses until the block has answered everything
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);

        // random arrays with idling on both sides
        run_arrays(200);
        // no idling at all
        send_gap_max = 0;
        recv_gap_max = 0;
        run_arrays(100);
        // long result stall while requests keep coming
        hold_request = 1'b1;
        run_arrays(80);
        send_gap_max = 10;
        recv_gap_max = 10;
        run_arrays(100);

        // array longer than the store: extra elements, the last one too, are dropped
        send_gap_max = 2;
        vals.delete();
        for (int i = 0; i < CAPACITY; i++)
            vals.push_back(t_word'(((i + 700) % CAPACITY) * 4096 - 2000000));
        vals.push_back(WORD_MIN);
        vals.push_back(WORD_MIN);
        send_values(vals);

        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d requests in %0d arrays, %0d minima compared", items_sent, arrays,
                 results);
        $display("rotated, repeated and unordered arrays, a long stall, overfull store");
        if (mismatches == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
